FILE: rtl/joint_pid_position_control_macros.svh
// assertion macros for the joint pid controller
`ifndef JOINT_PID_POSITION_CONTROL_MACROS_SVH
`define JOINT_PID_POSITION_CONTROL_MACROS_SVH

// implication in the same cycle
`define JPC_ASSERT_NOW(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
    else $error("check failed");

// implication into the next cycle
`define JPC_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
    else $error("check failed");

`endif

FILE: rtl/jpc_pkg.sv
package jpc_pkg;

  localparam int JOINTS_DEF    = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_AW        = 4;
  localparam int DIV_STEPS     = 64;
  localparam int DIV_CW        = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_RSVD    = 2'd3;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_PTOL = 2'd1;
  localparam logic [1:0] REG_VTOL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISP, ST_PREP, ST_VWAIT, ST_SQE, ST_SQV, ST_EDT, ST_LWAIT,
    ST_CLAMP, ST_PE, ST_DV, ST_ILO, ST_IHI, ST_RES, ST_OUT
  } st_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_DISP, OP_PREP, OP_VWAIT, OP_SQE, OP_SQV, OP_EDT, OP_CLAMP,
    OP_PE, OP_DV, OP_ILO, OP_IHI, OP_OUT
  } dp_op_t;

  typedef enum logic [2:0] {
    MT_NONE, MT_EE, MT_VV, MT_EDT, MT_PE, MT_DV, MT_ILO, MT_IHI
  } mul_t;

  typedef struct packed {
    logic   latch;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic is_sample;
    logic div_busy;
    logic mode1;
    logic out_busy;
  } stat_t;

endpackage

FILE: rtl/jpc_in_if.sv
interface jpc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [2:0]         joint;
  logic signed [31:0] angle;
  logic [31:0]        time_step;
  logic               frame_end;
  logic signed [31:0] target_angle;
  logic [30:0]        gain_p;
  logic [30:0]        gain_i;
  logic [30:0]        gain_d;
  logic [30:0]        integral_limit;

  modport source (output valid, command, joint, angle, time_step, frame_end, target_angle,
                  gain_p, gain_i, gain_d, integral_limit, input ready);
  modport sink (input valid, command, joint, angle, time_step, frame_end, target_angle,
                gain_p, gain_i, gain_d, integral_limit, output ready);
endinterface

FILE: rtl/jpc_out_if.sv
interface jpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] torque;
  logic [2:0]         joint_out;
  logic               frame_last;
  logic               finished;

  modport source (output valid, torque, joint_out, frame_last, finished, input ready);
  modport sink (input valid, torque, joint_out, frame_last, finished, output ready);
endinterface

FILE: rtl/jpc_div.sv
module jpc_div
  import jpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [63:0] quot
);

  logic [DIV_CW-1:0] cnt_r;
  logic [63:0]       q_r;
  logic [32:0]       rem_r;
  logic [31:0]       den_r;
  logic [32:0]       rsh;
  logic              ge;

  assign rsh  = {rem_r[31:0], q_r[63]};
  assign ge   = rsh >= {1'b0, den_r};
  assign busy = cnt_r != '0;
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CW'(DIV_STEPS);
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= ge ? rsh - {1'b0, den_r} : rsh;
      q_r   <= {q_r[62:0], ge};
    end
  end

endmodule

FILE: rtl/jpc_dp.sv
module jpc_dp
  import jpc_pkg::*;
#(
  parameter int JOINTS = JOINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [1:0]         in_command,
  input  logic [2:0]         in_joint,
  input  logic signed [31:0] in_angle,
  input  logic [31:0]        in_time_step,
  input  logic               in_frame_end,
  input  logic signed [31:0] in_target_angle,
  input  logic [30:0]        in_gain_p,
  input  logic [30:0]        in_gain_i,
  input  logic [30:0]        in_gain_d,
  input  logic [30:0]        in_integral_limit,
  input  logic               mode,
  input  logic [15:0]        ptol,
  input  logic [15:0]        vtol,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_torque,
  output logic [2:0]         out_joint,
  output logic               out_last,
  output logic               out_fin
);

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic signed [61:0] A_MAX = 62'sd140737488355327;
  localparam logic signed [61:0] A_MIN = -62'sd140737488355328;
  localparam logic signed [52:0] T_MAX = 53'sd2147483647;
  localparam logic signed [52:0] T_MIN = -53'sd2147483648;

  // latched item
  logic [1:0]         cmd_r;
  logic [2:0]         jn_r;
  logic signed [31:0] ang_r;
  logic [31:0]        dt_r;
  logic               last_r;
  logic signed [31:0] tin_r;
  logic [30:0]        gpin_r, giin_r, gdin_r, lmin_r;

  // per-joint state
  logic signed [31:0] prev_r [JOINTS];
  logic signed [31:0] vel_r [JOINTS];
  logic signed [31:0] tgt_r [JOINTS];
  logic signed [47:0] integ_r [JOINTS];
  logic [30:0]        gp_r [JOINTS];
  logic [30:0]        gi_r [JOINTS];
  logic [30:0]        gd_r [JOINTS];
  logic [30:0]        lm_r [JOINTS];
  logic [JOINTS-1:0]  seen_r;

  // work registers
  logic signed [31:0] e_r;
  logic               vdiv_r, vneg_r;
  logic signed [47:0] acc_r, acc_nxt, acc_clamp;
  logic signed [63:0] prod_r, prod_nxt;
  mul_t               ptag_r, tag_nxt;
  logic signed [51:0] tsum_r, tsum_nxt;
  logic [63:0]        esum_r, esum_nxt, vsum_r, vsum_nxt;
  logic               out_valid_r;
  logic signed [31:0] out_torque_r;
  logic [2:0]         out_joint_r;
  logic               out_last_r, out_fin_r;

  logic [JW-1:0]      idx;
  logic               jok, is_load, is_rst, out_busy;
  logic signed [32:0] de, dv;
  logic signed [31:0] e_sat, vres, tq;
  logic [32:0]        dmag;
  logic               vstart, div_start, div_busy;
  logic [63:0]        div_num, dquot;
  logic [31:0]        div_den;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mprod;
  logic [64:0]        es, vs;
  logic signed [61:0] asum;
  logic signed [64:0] acc65, lim65, nlim65;
  logic signed [52:0] ntq;
  logic [31:0]        pt2, vt2;
  logic               fin;

  assign idx      = JW'(jn_r);
  assign jok      = {29'b0, jn_r} < 32'(JOINTS);
  assign is_load  = cmd_r == CMD_LOAD;
  assign is_rst   = cmd_r == CMD_RESTART;
  assign out_busy = out_valid_r && !out_ready;

  assign stat.is_sample = (cmd_r == CMD_SAMPLE) && jok;
  assign stat.div_busy  = div_busy;
  assign stat.mode1     = mode;
  assign stat.out_busy  = out_busy;

  assign de    = {ang_r[31], ang_r} - {tgt_r[idx][31], tgt_r[idx]};
  assign e_sat = (de[32] != de[31]) ? (de[32] ? 32'sh80000000 : 32'sh7fffffff) : de[31:0];
  assign dv    = {ang_r[31], ang_r} - {prev_r[idx][31], prev_r[idx]};
  assign dmag  = dv[32] ? 33'(-dv) : 33'(dv);
  assign vstart = seen_r[idx] && (dt_r != '0);

  // velocity from the unsigned quotient, saturated
  always_comb begin
    if (!vneg_r) vres = (dquot > 64'd2147483647) ? 32'sh7fffffff : dquot[31:0];
    else vres = (dquot > 64'd2147483648) ? 32'sh80000000 : ~dquot[31:0] + 32'd1;
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = {11'b0, dmag, 20'b0};
    div_den   = dt_r;
    if (cmd.op == OP_PREP) begin
      div_start = vstart;
    end else if (cmd.op == OP_EDT) begin
      div_start = gi_r[idx] != '0;
      div_num   = {1'b0, lm_r[idx], 32'b0};
      div_den   = {1'b0, gi_r[idx]};
    end
  end

  jpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (dquot)
  );

  // shared multiplier
  always_comb begin
    tag_nxt = MT_NONE;
    mul_a   = 33'(e_r);
    mul_b   = 33'(e_r);
    unique case (cmd.op)
      OP_SQE: tag_nxt = MT_EE;
      OP_SQV: begin
        tag_nxt = MT_VV;
        mul_a   = 33'(vel_r[idx]);
        mul_b   = 33'(vel_r[idx]);
      end
      OP_EDT: begin
        tag_nxt = MT_EDT;
        mul_b   = {1'b0, dt_r};
      end
      OP_PE: begin
        tag_nxt = MT_PE;
        mul_a   = {2'b0, gp_r[idx]};
      end
      OP_DV: begin
        tag_nxt = MT_DV;
        mul_a   = {2'b0, gd_r[idx]};
        mul_b   = 33'(vel_r[idx]);
      end
      OP_ILO: begin
        tag_nxt = MT_ILO;
        mul_a   = {1'b0, acc_r[31:0]};
        mul_b   = {2'b0, gi_r[idx]};
      end
      OP_IHI: begin
        tag_nxt = MT_IHI;
        mul_a   = 33'($signed(acc_r[47:32]));
        mul_b   = {2'b0, gi_r[idx]};
      end
      default: tag_nxt = MT_NONE;
    endcase
  end

  assign mprod    = mul_a * mul_b;
  assign prod_nxt = mprod[63:0];

  assign es     = {1'b0, esum_r} + {1'b0, prod_r};
  assign vs     = {1'b0, vsum_r} + {1'b0, prod_r};
  assign asum   = 62'(integ_r[idx]) + 62'(prod_r >>> 4);
  assign acc65  = 65'(acc_r);
  assign lim65  = {1'b0, dquot};
  assign nlim65 = -lim65;
  assign pt2    = {16'b0, ptol} * {16'b0, ptol};
  assign vt2    = {16'b0, vtol} * {16'b0, vtol};
  assign ntq    = -{tsum_r[51], tsum_r};
  assign tq     = (ntq > T_MAX) ? 32'sh7fffffff : (ntq < T_MIN) ? 32'sh80000000 : ntq[31:0];
  assign fin    = last_r && (!mode || ((esum_r < {32'b0, pt2}) && (vsum_r < {32'b0, vt2})));

  always_comb begin
    acc_clamp = acc_r;
    if (gi_r[idx] != '0) begin
      if (acc65 > lim65) acc_clamp = dquot[47:0];
      else if (acc65 < nlim65) acc_clamp = nlim65[47:0];
    end
  end

  // consume the product issued in the previous cycle
  always_comb begin
    esum_nxt = esum_r;
    vsum_nxt = vsum_r;
    acc_nxt  = acc_r;
    tsum_nxt = tsum_r;
    case (ptag_r)
      MT_EE:  esum_nxt = es[64] ? '1 : es[63:0];
      MT_VV:  vsum_nxt = vs[64] ? '1 : vs[63:0];
      MT_EDT: acc_nxt = (asum > A_MAX) ? A_MAX[47:0] : (asum < A_MIN) ? A_MIN[47:0] : asum[47:0];
      MT_PE:  tsum_nxt = 52'(prod_r >>> 16);
      MT_DV:  tsum_nxt = tsum_r + 52'(prod_r >>> 16);
      MT_ILO: tsum_nxt = tsum_r + {20'b0, prod_r[63:32]};
      MT_IHI: tsum_nxt = tsum_r + 52'(prod_r);
      default: tsum_nxt = tsum_r;
    endcase
    if (cmd.op == OP_CLAMP) acc_nxt = acc_clamp;
    if (cmd.op == OP_OUT && !out_busy && last_r) begin
      esum_nxt = '0;
      vsum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < JOINTS; j++) begin
        prev_r[j]  <= '0;
        vel_r[j]   <= '0;
        tgt_r[j]   <= '0;
        integ_r[j] <= '0;
        gp_r[j]    <= '0;
        gi_r[j]    <= '0;
        gd_r[j]    <= '0;
        lm_r[j]    <= '0;
      end
      seen_r      <= '0;
      esum_r      <= '0;
      vsum_r      <= '0;
      ptag_r      <= MT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.latch) begin
        cmd_r  <= in_command;
        jn_r   <= in_joint;
        ang_r  <= in_angle;
        dt_r   <= in_time_step;
        last_r <= in_frame_end;
        tin_r  <= in_target_angle;
        gpin_r <= in_gain_p;
        giin_r <= in_gain_i;
        gdin_r <= in_gain_d;
        lmin_r <= in_integral_limit;
      end
      ptag_r <= tag_nxt;
      prod_r <= prod_nxt;
      esum_r <= esum_nxt;
      vsum_r <= vsum_nxt;
      acc_r  <= acc_nxt;
      tsum_r <= tsum_nxt;
      case (cmd.op)
        OP_DISP: begin
          if (is_load && jok) begin
            tgt_r[idx] <= tin_r;
            gp_r[idx]  <= gpin_r;
            gi_r[idx]  <= giin_r;
            gd_r[idx]  <= gdin_r;
            lm_r[idx]  <= lmin_r;
          end
          if (is_rst) begin
            for (int j = 0; j < JOINTS; j++) integ_r[j] <= '0;
            seen_r <= '0;
          end
        end
        OP_PREP: begin
          e_r         <= e_sat;
          vdiv_r      <= vstart;
          vneg_r      <= dv[32];
          prev_r[idx] <= ang_r;
          seen_r[idx] <= 1'b1;
        end
        OP_VWAIT: if (!div_busy && vdiv_r) vel_r[idx] <= vres;
        OP_CLAMP: integ_r[idx] <= acc_clamp;
        default: ;
      endcase
      if (cmd.op == OP_OUT && !out_busy) begin
        out_valid_r  <= 1'b1;
        out_torque_r <= mode ? tq : '0;
        out_joint_r  <= jn_r;
        out_last_r   <= last_r;
        out_fin_r    <= fin;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_torque = out_torque_r;
  assign out_joint  = out_joint_r;
  assign out_last   = out_last_r;
  assign out_fin    = out_fin_r;

endmodule

FILE: rtl/jpc_ctrl.sv
module jpc_ctrl
  import jpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  st_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_valid) st_nxt = ST_DISP;
      ST_DISP:  st_nxt = stat.is_sample ? ST_PREP : ST_IDLE;
      ST_PREP:  st_nxt = ST_VWAIT;
      ST_VWAIT: if (!stat.div_busy) st_nxt = ST_SQE;
      ST_SQE:   st_nxt = ST_SQV;
      ST_SQV:   st_nxt = stat.mode1 ? ST_EDT : ST_RES;
      ST_EDT:   st_nxt = ST_LWAIT;
      ST_LWAIT: if (!stat.div_busy) st_nxt = ST_CLAMP;
      ST_CLAMP: st_nxt = ST_PE;
      ST_PE:    st_nxt = ST_DV;
      ST_DV:    st_nxt = ST_ILO;
      ST_ILO:   st_nxt = ST_IHI;
      ST_IHI:   st_nxt = ST_RES;
      ST_RES:   st_nxt = ST_OUT;
      ST_OUT:   if (!stat.out_busy) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.latch = 1'b0;
    cmd.op    = OP_NONE;
    unique case (st_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_DISP:  cmd.op = OP_DISP;
      ST_PREP:  cmd.op = OP_PREP;
      ST_VWAIT: cmd.op = OP_VWAIT;
      ST_SQE:   cmd.op = OP_SQE;
      ST_SQV:   cmd.op = OP_SQV;
      ST_EDT:   cmd.op = OP_EDT;
      ST_CLAMP: cmd.op = OP_CLAMP;
      ST_PE:    cmd.op = OP_PE;
      ST_DV:    cmd.op = OP_DV;
      ST_ILO:   cmd.op = OP_ILO;
      ST_IHI:   cmd.op = OP_IHI;
      ST_OUT:   cmd.op = OP_OUT;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

FILE: rtl/joint_pid_position_control.sv
// per-joint pid position controller
// in_chan: one item per transfer; command selects sample, load of joint settings
//   or restart. load and restart give no result.
// out_chan: one result per sample of a joint in range: torque, joint, frame flag
//   and settle flag.
// a sample result is loaded once its steps are done; control off skips the pid
//   steps. it waits for the velocity division when the joint has a previous
//   sample and a nonzero time step, and for the integral bound division when
//   pid mode is on and the integral gain is nonzero. the next transfer is taken
//   once the result is loaded. both divisions run on one serial divider, one
//   quotient bit a cycle; the products share one multiplier.
// one item is worked on at a time; in_chan.ready is high only when idle.
// a finished result waits in the output register; a new item is accepted
//   while it waits, and the next result holds until out_chan.ready takes it.
// cfg port: apb writes and reads of mode (0x0), position tolerance (0x4) and
//   velocity tolerance (0x8); write only while idle.
// reset: joint settings, integrals and frame sums cleared, mode off,
//   tolerances set to 0.385 and 0.03 in angle format.
module joint_pid_position_control
  import jpc_pkg::*;
#(
  parameter int JOINTS          = JOINTS_DEF,
  parameter int ANGLE_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  jpc_in_if.sink            in_chan,
  jpc_out_if.source         out_chan,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam longint unsigned PT_RAW = (64'd385 << ANGLE_FRAC_BITS) / 64'd1000;
  localparam longint unsigned VT_RAW = (64'd3 << ANGLE_FRAC_BITS) / 64'd100;
  localparam logic [15:0] PT_RST = (PT_RAW > 64'd65535) ? 16'hffff : PT_RAW[15:0];
  localparam logic [15:0] VT_RST = (VT_RAW > 64'd65535) ? 16'hffff : VT_RAW[15:0];

  logic        mode_r;
  logic [15:0] ptol_r, vtol_r;
  logic        wr;
  cmd_t        cmd;
  stat_t       stat;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      ptol_r <= PT_RST;
      vtol_r <= VT_RST;
    end else if (wr) begin
      unique case (cfg_paddr[3:2])
        REG_MODE: mode_r <= cfg_pwdata[0];
        REG_PTOL: ptol_r <= cfg_pwdata[15:0];
        REG_VTOL: vtol_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MODE: cfg_prdata = {31'b0, mode_r};
      REG_PTOL: cfg_prdata = {16'b0, ptol_r};
      REG_VTOL: cfg_prdata = {16'b0, vtol_r};
      default:  cfg_prdata = '0;
    endcase
  end

  jpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  jpc_dp #(.JOINTS(JOINTS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_command        (in_chan.command),
    .in_joint          (in_chan.joint),
    .in_angle          (in_chan.angle),
    .in_time_step      (in_chan.time_step),
    .in_frame_end      (in_chan.frame_end),
    .in_target_angle   (in_chan.target_angle),
    .in_gain_p         (in_chan.gain_p),
    .in_gain_i         (in_chan.gain_i),
    .in_gain_d         (in_chan.gain_d),
    .in_integral_limit (in_chan.integral_limit),
    .mode              (mode_r),
    .ptol              (ptol_r),
    .vtol              (vtol_r),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_torque        (out_chan.torque),
    .out_joint         (out_chan.joint_out),
    .out_last          (out_chan.frame_last),
    .out_fin           (out_chan.finished)
  );

endmodule

FILE: rtl/jpc_checker.sv
`include "joint_pid_position_control_macros.svh"

module jpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] torque,
  input logic        frame_last,
  input logic        finished
);

  // a stalled result holds
  `JPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(torque))

  // settle flag only on the frame's last joint
  `JPC_ASSERT_NOW(a_fin_last, clk, rst_n, out_valid && !frame_last, !finished)

  // one item at a time
  `JPC_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind joint_pid_position_control jpc_checker u_jpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .torque     (out_chan.torque),
  .frame_last (out_chan.frame_last),
  .finished   (out_chan.finished)
);
